// ===== rtl/srmtf_pkg.sv =====
`default_nettype none

package srmtf_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int OP_W = 2;
    localparam int POS_W = 10;
    localparam int LEN_W = 11;
    localparam int ENTRY_W = 11;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/sequence_range_move_to_front_core.sv =====
`default_nettype none

// Keeps an ordered sequence of up to DEPTH entries in block memory and serves one request at a
// time: initialize, move a range to the front, or read one position. A request is taken when
// start is high and busy is low; its single result appears on entry_value and bad_request for
// exactly one cycle with result_valid, and the receiver cannot stall it. After reset the block
// is busy while it writes the identity order. A rejected request gets its result straight from
// the idle state, a read once the addressed entry has been read out, an initialize once the
// identity order has been written, and a move of the range first..last once it has copied
// positions 0..last into a scratch memory in rotated order and back again, one entry per cycle
// through the single write port of each memory. A new request may be issued in the cycle its
// predecessor's result is shown.

module sequence_range_move_to_front_core
    import srmtf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [POS_W-1:0]   first_position,
    input  wire logic [POS_W-1:0]   last_position,
    input  wire logic [POS_W-1:0]   read_position,
    input  wire logic               config_write,
    input  wire logic [LEN_W-1:0]   sequence_length,
    output logic                    result_valid,
    output logic [ENTRY_W-1:0]      entry_value,
    output logic                    bad_request
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_ROT  = 3'd2;
    localparam logic [2:0] S_COPY = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;

    logic [ENTRY_W-1:0] store_mem [DEPTH];
    logic [ENTRY_W-1:0] scratch_mem [DEPTH];

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               reply_reg, reply_next;
    logic [POS_W-1:0]   first_reg, first_next;
    logic [POS_W-1:0]   last_reg, last_next;
    logic [LEN_W-1:0]   length_reg;
    logic               valid_reg, valid_next;
    logic [ENTRY_W-1:0] value_reg, value_next;
    logic               bad_reg, bad_next;

    logic [ENTRY_W-1:0] store_rdata_reg;
    logic [ENTRY_W-1:0] scratch_rdata_reg;
    logic [AW-1:0]      store_raddr;
    logic [AW-1:0]      store_waddr;
    logic [ENTRY_W-1:0] store_wdata;
    logic               store_we;
    logic               scratch_we;

    logic [CW-1:0]      eff_len;
    logic [CW-1:0]      src_sum;
    logic [CW-1:0]      src_pos;
    logic [CW-1:0]      last_ext;
    logic [CW-1:0]      first_in_ext;
    logic [CW-1:0]      last_in_ext;
    logic [CW-1:0]      read_in_ext;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign entry_value  = value_reg;
    assign bad_request  = bad_reg;

    assign eff_len = (CW'(length_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(length_reg);
    assign last_ext     = CW'(last_reg);
    assign first_in_ext = CW'(first_position);
    assign last_in_ext  = CW'(last_position);
    assign read_in_ext  = CW'(read_position);

    assign src_sum = CW'(first_reg) + cnt_reg;
    assign src_pos = (src_sum > last_ext) ? (src_sum - last_ext - CW'(1)) : src_sum;

    always_comb
    begin
        store_raddr = (state_reg == S_ROT) ? src_pos[AW-1:0] : read_in_ext[AW-1:0];
        store_we    = (state_reg == S_INIT) || ((state_reg == S_COPY) && pend_reg);
        store_waddr = (state_reg == S_INIT) ? cnt_reg[AW-1:0] : idx_reg;
        store_wdata = (state_reg == S_INIT) ? ENTRY_W'(cnt_reg + CW'(1)) : scratch_rdata_reg;
        scratch_we  = (state_reg == S_ROT) && pend_reg;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rdata_reg <= store_mem[store_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (scratch_we)
        begin
            scratch_mem[idx_reg] <= store_rdata_reg;
        end
        scratch_rdata_reg <= scratch_mem[cnt_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        reply_next = reply_reg;
        first_next = first_reg;
        last_next  = last_reg;
        valid_next = 1'b0;
        value_next = value_reg;
        bad_next   = bad_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    first_next = first_position;
                    last_next  = last_position;
                    cnt_next   = '0;
                    case (operation)
                        OP_INIT:
                        begin
                            state_next = S_INIT;
                            reply_next = 1'b1;
                        end
                        OP_MOVE:
                        begin
                            if ((first_in_ext > last_in_ext) || (last_in_ext >= eff_len))
                            begin
                                valid_next = 1'b1;
                                value_next = '0;
                                bad_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ROT;
                            end
                        end
                        OP_READ:
                        begin
                            if (read_in_ext >= eff_len)
                            begin
                                valid_next = 1'b1;
                                value_next = '0;
                                bad_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            valid_next = 1'b1;
                            value_next = '0;
                            bad_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                if (cnt_reg == CW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    valid_next = reply_reg;
                    value_next = '0;
                    bad_next   = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_ROT, S_COPY:
            begin
                if (cnt_reg > last_ext)
                begin
                    cnt_next = '0;
                    if (state_reg == S_ROT)
                    begin
                        state_next = S_COPY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        valid_next = 1'b1;
                        value_next = '0;
                        bad_next   = 1'b0;
                    end
                end
                else
                begin
                    pend_next = 1'b1;
                    idx_next  = cnt_reg[AW-1:0];
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
                valid_next = 1'b1;
                value_next = store_rdata_reg;
                bad_next   = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            reply_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            length_reg <= LENGTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            reply_reg <= reply_next;
            valid_reg <= valid_next;
            if (config_write)
            begin
                length_reg <= sequence_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        value_reg <= value_next;
        bad_reg   <= bad_next;
    end

endmodule

`default_nettype wire
